/* hw/rtl/quadratic_outline_decomposer_top_assert.svh */
// Assertion macros shared by the checker of the outline decomposer.
`ifndef QUADRATIC_OUTLINE_DECOMPOSER_TOP_ASSERT_SVH
`define QUADRATIC_OUTLINE_DECOMPOSER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define QOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/qod_pkg.sv */
`default_nettype none

package qod_pkg;

  // Path command codes.
  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_LINE = 2'd1;
  localparam logic [1:0] CMD_QUAD = 2'd2;

  // Point tags.
  localparam logic [1:0] TAG_CONIC = 2'd0;
  localparam logic [1:0] TAG_ON    = 2'd1;

  // How many results one point produces.
  typedef struct packed {
    logic any;  // at least one result
    logic two;  // a second result follows the first
  } qod_emit_t;

endpackage

`default_nettype wire

/* hw/rtl/qod_decode.sv */
`default_nettype none

module qod_decode
  import qod_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [COORD_BITS-1:0]         px_i,
  input  wire logic [COORD_BITS-1:0]         py_i,
  input  wire logic [1:0]                    tag_i,
  input  wire logic                          first_i,
  input  wire logic                          last_i,
  output qod_emit_t                          emit_o,
  output logic      [4*(COORD_BITS+1)+3:0]   res0_o,
  output logic      [4*(COORD_BITS+1)+3:0]   res1_o
);

  localparam int OW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] start_x_q, start_y_q, start_x_d, start_y_d;
  logic [COORD_BITS-1:0] pend_x_q, pend_y_q, pend_x_d, pend_y_d;
  logic                  pend_v_q, pend_v_d;

  logic          main_v;
  logic [1:0]    main_cmd;
  logic [OW-1:0] main_ex, main_ey, main_cx, main_cy;
  logic [1:0]    close_cmd;
  logic [OW-1:0] close_ex, close_ey, close_cx, close_cy;

  // A 18.6 coordinate with one more fraction bit.
  function automatic logic [OW-1:0] widen(input logic [COORD_BITS-1:0] v);
    return {v, 1'b0};
  endfunction

  // Sum of two 18.6 coordinates is the midpoint with one more fraction bit.
  function automatic logic [OW-1:0] mid(input logic [COORD_BITS-1:0] a,
                                        input logic [COORD_BITS-1:0] b);
    return {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
  endfunction

  always_comb begin
    main_v    = 1'b0;
    main_cmd  = CMD_LINE;
    main_ex   = widen(px_i);
    main_ey   = widen(py_i);
    main_cx   = '0;
    main_cy   = '0;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    pend_x_d  = pend_x_q;
    pend_y_d  = pend_y_q;
    pend_v_d  = pend_v_q;
    if (first_i) begin
      main_v    = 1'b1;
      main_cmd  = CMD_MOVE;
      start_x_d = px_i;
      start_y_d = py_i;
      pend_v_d  = 1'b0;
    end else begin
      unique case (tag_i)
        TAG_ON: begin
          main_v = 1'b1;
          if (pend_v_q) begin
            main_cmd = CMD_QUAD;
            main_cx  = widen(pend_x_q);
            main_cy  = widen(pend_y_q);
            pend_v_d = 1'b0;
          end
        end
        TAG_CONIC: begin
          // A second control implies an on-curve point halfway between.
          if (pend_v_q) begin
            main_v   = 1'b1;
            main_cmd = CMD_QUAD;
            main_ex  = mid(pend_x_q, px_i);
            main_ey  = mid(pend_y_q, py_i);
            main_cx  = widen(pend_x_q);
            main_cy  = widen(pend_y_q);
          end
          pend_x_d = px_i;
          pend_y_d = py_i;
          pend_v_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The closing segment sees the state as left by this point.
  always_comb begin
    close_ex  = widen(start_x_d);
    close_ey  = widen(start_y_d);
    close_cmd = pend_v_d ? CMD_QUAD : CMD_LINE;
    close_cx  = pend_v_d ? widen(pend_x_d) : '0;
    close_cy  = pend_v_d ? widen(pend_y_d) : '0;
  end

  assign emit_o.any = main_v | last_i;
  assign emit_o.two = main_v & last_i;

  // Word layout from the top: last, closes, command, ctrl_y, ctrl_x, end_y, end_x.
  assign res0_o = main_v ? {~last_i, 1'b0, main_cmd, main_cy, main_cx, main_ey, main_ex}
                         : {1'b1, 1'b1, close_cmd, close_cy, close_cx, close_ey, close_ex};
  assign res1_o = {1'b1, 1'b1, close_cmd, close_cy, close_cx, close_ey, close_ex};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      pend_x_q  <= '0;
      pend_y_q  <= '0;
      pend_v_q  <= 1'b0;
    end else if (fire_i) begin
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      pend_x_q  <= pend_x_d;
      pend_y_q  <= pend_y_d;
      pend_v_q  <= pend_v_d & ~last_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/qod_outbuf.sv */
`default_nettype none

module qod_outbuf
  import qod_pkg::*;
#(
  parameter int WIDTH = 104
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire qod_emit_t        emit_i,
  input  wire logic [WIDTH-1:0] word0_i,
  input  wire logic [WIDTH-1:0] word1_i,
  input  wire logic             ready_i,
  output logic                  free_o,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] word_o
);

  logic             head_v_q, tail_v_q;
  logic [WIDTH-1:0] head_q, tail_q;

  // The head can take new results once it is empty or leaves this cycle
  // with nothing queued behind it.
  assign free_o  = ~head_v_q | (ready_i & ~tail_v_q);
  assign valid_o = head_v_q;
  assign word_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      if (head_v_q && ready_i) begin
        if (tail_v_q) begin
          tail_v_q <= 1'b0;
        end else begin
          head_v_q <= 1'b0;
        end
      end
      if (load_i && emit_i.any) begin
        head_v_q <= 1'b1;
        tail_v_q <= emit_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_v_q && ready_i && tail_v_q) begin
      head_q <= tail_q;
    end
    if (load_i && emit_i.any) begin
      head_q <= word0_i;
      tail_q <= word1_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/quadratic_outline_decomposer_top.sv */
// Channel    Dir  tdata                        tuser                    tlast
// s_axis     in   point_x, point_y             tag, contour_first       contour_last
// m_axis     out  end_x, end_y, ctrl_x, ctrl_y command, closes_contour  last
//
// One point is taken per cycle while its results fit in the output buffer. A
// point that yields two results (a segment plus the closing segment) holds the
// output buffer, so the input stalls behind it.
// Reset clears the contour start, the pending conic control and all valids.
// Either side may stall at any time; nothing is lost or repeated.
`default_nettype none

module quadratic_outline_decomposer_top
  import qod_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // point_x, point_y (lowest bits first), zero padded to whole bytes
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  // tag [1:0], contour_first [2]
  input  wire logic [2:0]                             s_axis_tuser_i,
  input  wire logic                                   s_axis_tlast_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // end_x, end_y, ctrl_x, ctrl_y (lowest bits first), zero padded to whole bytes
  output logic      [((4*(COORD_BITS+1)+7)/8)*8-1:0]  m_axis_tdata_o,
  // command [1:0], closes_contour [2]
  output logic      [2:0]                             m_axis_tuser_o,
  output logic                                        m_axis_tlast_o
);

  localparam int OW     = COORD_BITS + 1;
  localparam int OUT_DW = ((4*OW+7)/8)*8;
  localparam int RES_W  = 4*OW + 4;

  // Input register: the point waiting to be decoded.
  logic                  in_v_q;
  logic [COORD_BITS-1:0] in_x_q, in_y_q;
  logic [1:0]            in_tag_q;
  logic                  in_first_q, in_last_q;

  qod_emit_t         emit;
  logic [RES_W-1:0]  res0, res1, out_word;
  logic              out_free, fire;

  // A point is decoded when its results fit in the output buffer; a point
  // with no results always passes.
  assign fire            = in_v_q & (~emit.any | out_free);
  assign s_axis_tready_o = ~in_v_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_x_q     <= s_axis_tdata_i[COORD_BITS-1:0];
      in_y_q     <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      in_tag_q   <= s_axis_tuser_i[1:0];
      in_first_q <= s_axis_tuser_i[2];
      in_last_q  <= s_axis_tlast_i;
    end
  end

  qod_decode #(
    .COORD_BITS(COORD_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .px_i   (in_x_q),
    .py_i   (in_y_q),
    .tag_i  (in_tag_q),
    .first_i(in_first_q),
    .last_i (in_last_q),
    .emit_o (emit),
    .res0_o (res0),
    .res1_o (res1)
  );

  qod_outbuf #(
    .WIDTH(RES_W)
  ) u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .emit_i (emit),
    .word0_i(res0),
    .word1_i(res1),
    .ready_i(m_axis_tready_i),
    .free_o (out_free),
    .valid_o(m_axis_tvalid_o),
    .word_o (out_word)
  );

  // Result word: last, closes, command, then the four coordinates.
  assign m_axis_tdata_o = OUT_DW'(out_word[4*OW-1:0]);
  assign m_axis_tuser_o = {out_word[4*OW+2], out_word[4*OW+1:4*OW]};
  assign m_axis_tlast_o = out_word[4*OW+3];

endmodule

`default_nettype wire

/* hw/rtl/qod_checker.sv */
`default_nettype none

`include "quadratic_outline_decomposer_top_assert.svh"

module qod_checker
  import qod_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   s_axis_tvalid_i,
  input wire logic                                   s_axis_tready_o,
  input wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  input wire logic [2:0]                             s_axis_tuser_i,
  input wire logic                                   s_axis_tlast_i,
  input wire logic                                   m_axis_tvalid_o,
  input wire logic                                   m_axis_tready_i,
  input wire logic [((4*(COORD_BITS+1)+7)/8)*8-1:0]  m_axis_tdata_o,
  input wire logic [2:0]                             m_axis_tuser_o,
  input wire logic                                   m_axis_tlast_o
);

  localparam int OW = COORD_BITS + 1;

  logic [1:0] cmd;
  logic       closes;
  logic       no_ctrl;

  assign cmd     = m_axis_tuser_o[1:0];
  assign closes  = m_axis_tuser_o[2];
  assign no_ctrl = (m_axis_tdata_o[4*OW-1:2*OW] == '0);

  `QOD_ASSERT(a_hold_on_stall, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "result changed while stalled")
  `QOD_ASSERT(a_straight_no_ctrl, m_axis_tvalid_o && (cmd == CMD_MOVE || cmd == CMD_LINE) |-> no_ctrl, "move or line carries a control point")
  `QOD_ASSERT(a_close_is_last, m_axis_tvalid_o && closes |-> m_axis_tlast_o && cmd != CMD_MOVE, "closing segment is not the final result of its point")
  `QOD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "result offered during reset")

endmodule

bind quadratic_outline_decomposer_top qod_checker #(
  .COORD_BITS(COORD_BITS)
) u_qod_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
  import qod_pkg::*;

  localparam int COORD_BITS = 24;
  localparam int SEG_W = COORD_BITS + 1;
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((4 * (COORD_BITS + 1) + 7) / 8) * 8;

  // The package names only the conic and on-curve tags. The other two codes
  // both yield no segment of their own from the decomposer.
  localparam logic [1:0] TAG_CUBIC = 2'd2;
  localparam logic [1:0] TAG_RSVD  = 2'd3;

  localparam int XMAX = 8388607;
  localparam int XMIN = -8388608;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // One outline point as it enters on the slave side.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [1:0]                   tag;
    logic                         first;
    logic                         last;
  } point_t;

  // One path command as it leaves on the master side.
  typedef struct packed {
    logic [1:0]                 command;
    logic signed [COORD_BITS:0] end_x;
    logic signed [COORD_BITS:0] end_y;
    logic signed [COORD_BITS:0] ctrl_x;
    logic signed [COORD_BITS:0] ctrl_y;
    logic                       closes;
    logic                       last;
  } seg_t;

  // A row of the directed table. When hand_checked is set, the command in
  // want replaces the predicted one in the expected stream.
  typedef struct {
    point_t pt;
    bit     hand_checked;
    seg_t   want;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_tvalid = 1'b0;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic [2:0]       s_tuser  = '0;
  logic             s_tlast  = 1'b0;
  logic             m_tready = 1'b0;

  wire logic             s_axis_tready_o;
  wire logic             m_axis_tvalid_o;
  wire logic [OUT_W-1:0] m_axis_tdata_o;
  wire logic [2:0]       m_axis_tuser_o;
  wire logic             m_axis_tlast_o;

  quadratic_outline_decomposer_top #(
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the decomposer's state, advanced once per accepted point.
  logic signed [COORD_BITS-1:0] contour_x  = '0;
  logic signed [COORD_BITS-1:0] contour_y  = '0;
  logic signed [COORD_BITS-1:0] conic_x    = '0;
  logic signed [COORD_BITS-1:0] conic_y    = '0;
  logic                         conic_held = 1'b0;

  seg_t step_out [2];
  seg_t path_cmds_q [$];
  row_t directed_rows [$];

  int  pts_sent     = 0;
  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  bit  idle_on      = 1'b1;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;

  // A 18.6 coordinate gains one fraction bit on the way out.
  function automatic logic signed [COORD_BITS:0] widen(input logic signed [COORD_BITS-1:0] v);
    return {v, 1'b0};
  endfunction

  function automatic seg_t segment(input logic [1:0] cmd,
                                   input logic signed [COORD_BITS:0] ex, ey, cx, cy,
                                   input logic closes);
    seg_t s;
    s.command = cmd;
    s.end_x   = ex;
    s.end_y   = ey;
    s.ctrl_x  = cx;
    s.ctrl_y  = cy;
    s.closes  = closes;
    s.last    = 1'b0;
    return s;
  endfunction

  // Turns one point into zero, one or two path commands in step_out and
  // returns how many there are.
  function automatic int decompose_point(input point_t p);
    int n;
    logic signed [COORD_BITS:0] mx, my;
    n = 0;
    if (p.first) begin
      step_out[n] = segment(CMD_MOVE, widen(p.x), widen(p.y), '0, '0, 1'b0);
      n++;
      contour_x  = p.x;
      contour_y  = p.y;
      conic_held = 1'b0;
    end else if (p.tag == TAG_ON) begin
      if (conic_held) begin
        step_out[n] = segment(CMD_QUAD, widen(p.x), widen(p.y),
                              widen(conic_x), widen(conic_y), 1'b0);
        conic_held = 1'b0;
      end else begin
        step_out[n] = segment(CMD_LINE, widen(p.x), widen(p.y), '0, '0, 1'b0);
      end
      n++;
    end else if (p.tag == TAG_CONIC) begin
      // Two conic controls in a row imply an on-curve point halfway between;
      // the plain sum of the 18.6 values is that midpoint with 7 fraction bits.
      if (conic_held) begin
        mx = {conic_x[COORD_BITS-1], conic_x} + {p.x[COORD_BITS-1], p.x};
        my = {conic_y[COORD_BITS-1], conic_y} + {p.y[COORD_BITS-1], p.y};
        step_out[n] = segment(CMD_QUAD, mx, my, widen(conic_x), widen(conic_y), 1'b0);
        n++;
      end
      conic_x    = p.x;
      conic_y    = p.y;
      conic_held = 1'b1;
    end
    if (p.last) begin
      if (conic_held)
        step_out[n] = segment(CMD_QUAD, widen(contour_x), widen(contour_y),
                              widen(conic_x), widen(conic_y), 1'b1);
      else
        step_out[n] = segment(CMD_LINE, widen(contour_x), widen(contour_y), '0, '0, 1'b1);
      n++;
      conic_held = 1'b0;
    end
    if (n > 0)
      step_out[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_row(input int x, input int y, input logic [1:0] tag,
                                  input bit first, input bit last,
                                  input bit hand_checked = 1'b0, input seg_t want = '0);
    row_t r;
    r.pt.x         = x[COORD_BITS-1:0];
    r.pt.y         = y[COORD_BITS-1:0];
    r.pt.tag       = tag;
    r.pt.first     = first;
    r.pt.last      = last;
    r.hand_checked = hand_checked;
    r.want         = want;
    directed_rows.push_back(r);
  endfunction

  // Mostly uniform 24-bit values, with the extremes and the values around
  // zero showing up often.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0:       return XMAX[COORD_BITS-1:0];
      1:       return XMIN[COORD_BITS-1:0];
      2:       return '0;
      3:       return '1;
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [1:0] pick_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9)       return TAG_ON;
    else if (r < 17) return TAG_CONIC;
    else if (r < 19) return TAG_CUBIC;
    else             return TAG_RSVD;
  endfunction

  // Offers one point and waits for its transaction. The valid is only ever
  // lowered at the start of an idle gap, so it never drops and rises in the
  // same time step.
  task automatic send_point(input point_t p, input bit hand_checked = 1'b0,
                            input seg_t want = '0);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.y, p.x};
    s_tuser  <= {p.first, p.tag};
    s_tlast  <= p.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n = decompose_point(p);
    if (hand_checked)
      path_cmds_q.push_back(want);
    else
      for (int k = 0; k < n; k++) path_cmds_q.push_back(step_out[k]);
    pts_sent++;
  endtask

  // Either a well-formed contour of random content or, now and then, a single
  // point with random flags that may break the contour structure.
  task automatic send_random_unit();
    point_t p;
    int     len;
    if ($urandom_range(0, 6) == 0) begin
      p.x     = rand_coord();
      p.y     = rand_coord();
      p.tag   = 2'($urandom_range(0, 3));
      p.first = 1'($urandom_range(0, 1));
      p.last  = 1'($urandom_range(0, 1));
      send_point(p);
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        p.x     = rand_coord();
        p.y     = rand_coord();
        p.tag   = pick_tag();
        p.first = (i == 0);
        p.last  = (i == len - 1);
        send_point(p);
      end
    end
  endtask

  initial begin
    // Right after reset: a line from the zero start, then a conic pair and a
    // closing point with no contour ever opened.
    add_row(5, -3, TAG_ON, 1'b0, 1'b0, 1'b1,
            '{CMD_LINE, 25'sd10, -25'sd6, 25'sd0, 25'sd0, 1'b0, 1'b1});
    add_row(100, 200, TAG_CONIC, 1'b0, 1'b0);
    add_row(-7, 9, TAG_CONIC, 1'b0, 1'b0);
    add_row(1, 1, TAG_ON, 1'b0, 1'b1);
    // Coordinate extremes through move and line.
    add_row(XMAX, XMIN, TAG_ON, 1'b1, 1'b0, 1'b1,
            '{CMD_MOVE, 25'sd16777214, -25'sd16777216, 25'sd0, 25'sd0, 1'b0, 1'b1});
    add_row(XMIN, XMAX, TAG_ON, 1'b0, 1'b0, 1'b1,
            '{CMD_LINE, -25'sd16777216, 25'sd16777214, 25'sd0, 25'sd0, 1'b0, 1'b1});
    // Midpoints at both ends of the output range and across zero.
    add_row(XMAX, XMAX, TAG_CONIC, 1'b0, 1'b0);
    add_row(XMAX, XMAX, TAG_CONIC, 1'b0, 1'b0);
    add_row(XMIN, XMIN, TAG_CONIC, 1'b0, 1'b0);
    add_row(XMIN, XMIN, TAG_CONIC, 1'b0, 1'b0);
    // Cubic and reserved tags emit nothing, and the close keeps the conic.
    add_row(1234, -5678, TAG_CUBIC, 1'b0, 1'b0);
    add_row(0, 0, TAG_RSVD, 1'b0, 1'b0);
    add_row(-1, -1, TAG_CUBIC, 1'b0, 1'b1);
    // First and last at once, and a first point of every tag.
    add_row(42, -42, TAG_CONIC, 1'b1, 1'b1);
    add_row(7, 8, TAG_CUBIC, 1'b1, 1'b0);
    add_row(3, 4, TAG_CONIC, 1'b0, 1'b0);
    add_row(6, 7, TAG_ON, 1'b1, 1'b0);
    add_row(-100, 100, TAG_ON, 1'b0, 1'b1);
    // Points after a closed contour run on from the old start point.
    add_row(9, 9, TAG_CONIC, 1'b0, 1'b0);
    add_row(11, -11, TAG_ON, 1'b0, 1'b1);
    add_row(-5, 5, TAG_CONIC, 1'b0, 1'b1);
    add_row(77, 77, TAG_RSVD, 1'b0, 1'b1);
    add_row(XMIN, XMAX, TAG_RSVD, 1'b1, 1'b0);
    add_row(0, 0, TAG_ON, 1'b1, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_point(directed_rows[i].pt, directed_rows[i].hand_checked, directed_rows[i].want);

    // Random contours. Partway through, the receiver holds off long enough
    // for the decomposer to back up and stall its input.
    while (pts_sent < 200) begin
      if (!hold_done && pts_sent >= 100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_random_unit();
    end

    // The sender pauses until every expected command has come out.
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (path_cmds_q.size() != 0);

    while (pts_sent < 370) send_random_unit();

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    while (pts_sent < 470) send_random_unit();
    s_tvalid <= 1'b0;

    while (path_cmds_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("PASS quadratic_outline_decomposer_top");
    else
      $display("FAIL quadratic_outline_decomposer_top");
    $finish;
  end

  // Receiver: ready with random idle bursts, plus one long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic void check_field(input string name, input logic [COORD_BITS:0] want,
                                      input logic [COORD_BITS:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Every result transaction is matched against the oldest expected command.
  always @(posedge clk_i) begin : result_monitor
    seg_t got;
    seg_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.command = m_axis_tuser_o[1:0];
      got.closes  = m_axis_tuser_o[2];
      got.last    = m_axis_tlast_o;
      got.end_x   = m_axis_tdata_o[0*(COORD_BITS+1) +: COORD_BITS+1];
      got.end_y   = m_axis_tdata_o[1*(COORD_BITS+1) +: COORD_BITS+1];
      got.ctrl_x  = m_axis_tdata_o[2*(COORD_BITS+1) +: COORD_BITS+1];
      got.ctrl_y  = m_axis_tdata_o[3*(COORD_BITS+1) +: COORD_BITS+1];
      if (path_cmds_q.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %p", $time, got);
        mismatch_cnt++;
      end else begin
        want = path_cmds_q.pop_front();
        check_field("command", SEG_W'(want.command), SEG_W'(got.command));
        check_field("end_x", want.end_x, got.end_x);
        check_field("end_y", want.end_y, got.end_y);
        check_field("ctrl_x", want.ctrl_x, got.ctrl_x);
        check_field("ctrl_y", want.ctrl_y, got.ctrl_y);
        check_field("closes_contour", SEG_W'(want.closes), SEG_W'(got.closes));
        check_field("last", SEG_W'(want.last), SEG_W'(got.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL quadratic_outline_decomposer_top");
      $finish;
    end
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/qod_pkg.sv
hw/rtl/qod_decode.sv
hw/rtl/qod_outbuf.sv
hw/rtl/quadratic_outline_decomposer_top.sv
hw/rtl/qod_checker.sv
sim/tb_top.sv
